// ----- hdl/mdct_pkg.sv -----
// ----------------------------------------------------------------------------
// mdct_pkg
// Shared types, constants and microcode store for the MPPT duty cycle tracker
// ----------------------------------------------------------------------------
package mdct_pkg;

  localparam int PWM_PERIOD_DEF = 1280;

  localparam int VOLT_W = 16;
  localparam int DUTY_W = 11;
  localparam int QTH_W  = 16;
  localparam int KIND_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 32;

  localparam logic [QTH_W-1:0]  Q_ALPHA_RST    = QTH_W'(26);
  localparam logic [QTH_W-1:0]  Q_BETA_RST     = QTH_W'(128);
  localparam logic [DUTY_W-1:0] DUTY_MIN_RST   = DUTY_W'(300);
  localparam logic [DUTY_W-1:0] DUTY_MAX_RST   = DUTY_W'(800);
  localparam logic [DUTY_W-1:0] START_DUTY_RST = DUTY_W'(640);
  localparam logic [DUTY_W-1:0] FIRST_DUTY_RST = DUTY_W'(655);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Q_ALPHA    = 3'd0,
    REG_Q_BETA     = 3'd1,
    REG_DUTY_MIN   = 3'd2,
    REG_DUTY_MAX   = 3'd3,
    REG_START_DUTY = 3'd4,
    REG_FIRST_DUTY = 3'd5
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 3'd0,
    KIND_HALF_UP = 3'd1,
    KIND_HALF_DN = 3'd2,
    KIND_FULL_UP = 3'd3,
    KIND_FULL_DN = 3'd4
  } step_kind_t;

  // microcode fields
  typedef enum logic [2:0] {
    A_DIFF = 3'd0,
    A_T    = 3'd1,
    A_QA   = 3'd2,
    A_QB   = 3'd3
  } sel_a_t;

  typedef enum logic [2:0] {
    B_CUR = 3'd0,
    B_PER = 3'd1,
    B_DV  = 3'd2,
    B_DD  = 3'd3,
    B_SQ  = 3'd4
  } sel_b_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_DONE  = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(8);

  typedef struct packed {
    sel_a_t            sel_a;
    sel_b_t            sel_b;
    logic              t_ld;
    acc_op_t           acc_op;
    logic              mag_ld;
    logic              band_ld;
    logic              br_first;
    logic [STEP_W-1:0] target;
    logic              done;
    logic              first;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '0;

  function automatic ctrl_t mdct_ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = CTRL_NOP;
    unique case (step)
      4'd0: begin
        c.sel_a    = A_DIFF;
        c.sel_b    = B_CUR;
        c.br_first = 1'b1;
        c.target   = STEP_FIRST;
      end
      4'd1: begin
        c.sel_a = A_QA;
        c.sel_b = B_PER;
        c.t_ld  = 1'b1;
      end
      4'd2: begin
        c.sel_a = A_T;
        c.sel_b = B_DV;
        c.t_ld  = 1'b1;
      end
      4'd3: begin
        c.sel_a  = A_T;
        c.sel_b  = B_DD;
        c.acc_op = ACC_LOAD;
      end
      4'd4: begin
        c.sel_a  = A_QA;
        c.sel_b  = B_SQ;
        c.acc_op = ACC_ADD;
      end
      4'd5: begin
        c.sel_a  = A_QB;
        c.sel_b  = B_SQ;
        c.t_ld   = 1'b1;
        c.mag_ld = 1'b1;
      end
      4'd6: begin
        c.band_ld = 1'b1;
      end
      STEP_DONE: begin
        c.done = 1'b1;
      end
      STEP_FIRST: begin
        c.first = 1'b1;
      end
      default: begin
        c = CTRL_NOP;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/mdct_datapath.sv -----
// ----------------------------------------------------------------------------
// mdct_datapath
// Shared multiplier, accumulator and band compare driven by the microcode
// ----------------------------------------------------------------------------
module mdct_datapath #(
  parameter int PWM_PERIOD = mdct_pkg::PWM_PERIOD_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  mdct_pkg::ctrl_t              ctrl,
  input  logic [mdct_pkg::DUTY_W-1:0]  cur,
  input  logic [mdct_pkg::DUTY_W-1:0]  prv,
  input  logic [mdct_pkg::VOLT_W-1:0]  volt,
  input  logic [mdct_pkg::VOLT_W-1:0]  vprev,
  input  logic [mdct_pkg::QTH_W-1:0]   q_alpha,
  input  logic [mdct_pkg::QTH_W-1:0]   q_beta,
  output mdct_pkg::step_kind_t         kind
);
  import mdct_pkg::*;

  localparam int PW     = $clog2(PWM_PERIOD + 1);
  localparam int DIFF_W = ((PW > DUTY_W) ? PW : DUTY_W) + 1;
  localparam int DD_W   = DUTY_W + 1;
  localparam int DV_W   = VOLT_W + 1;
  localparam int P1_W   = DIFF_W + DD_W;
  localparam int VP_W   = VOLT_W + PW + 1;
  localparam int TH_W   = QTH_W + 2 * PW + 1;
  localparam int T_W0   = (P1_W > VP_W) ? P1_W : VP_W;
  localparam int T_W    = (T_W0 > TH_W) ? T_W0 : TH_W;
  localparam int SQ_W   = 2 * PW;
  localparam int B_W0   = (DV_W > SQ_W + 1) ? DV_W : SQ_W + 1;
  localparam int B_W    = (B_W0 > PW + 1) ? B_W0 : PW + 1;
  localparam int A_W    = T_W;
  localparam int PROD_W = A_W + B_W;
  localparam int Q_W    = PROD_W + 1;

  localparam logic [SQ_W-1:0] PER_SQ = SQ_W'(PWM_PERIOD) * SQ_W'(PWM_PERIOD);

  logic signed [DIFF_W-1:0] diff;
  logic signed [DD_W-1:0]   dd;
  logic signed [DV_W-1:0]   dv;
  logic signed [A_W-1:0]    op_a;
  logic signed [B_W-1:0]    op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [T_W-1:0]    t;
  logic signed [Q_W-1:0]    acc;
  logic [Q_W-1:0]           mag;
  logic                     pos;
  logic                     lt_a;
  logic                     lt_b;
  step_kind_t               kind_next;

  assign diff = DIFF_W'(PWM_PERIOD) - DIFF_W'(cur);
  assign dd   = DD_W'(cur) - DD_W'(prv);
  assign dv   = DV_W'(volt) - DV_W'(vprev);

  always_comb begin
    unique case (ctrl.sel_a)
      A_DIFF:  op_a = A_W'(diff);
      A_T:     op_a = t;
      A_QA:    op_a = A_W'({1'b0, q_alpha});
      A_QB:    op_a = A_W'({1'b0, q_beta});
      default: op_a = '0;
    endcase
  end

  // step one uses the voltage times period, routed through the qa slot
  always_comb begin
    unique case (ctrl.sel_b)
      B_CUR:   op_b = B_W'({1'b0, cur});
      B_PER:   op_b = B_W'(PWM_PERIOD);
      B_DV:    op_b = B_W'(dv);
      B_DD:    op_b = B_W'(dd);
      B_SQ:    op_b = B_W'({1'b0, PER_SQ});
      default: op_b = '0;
    endcase
  end

  logic signed [A_W-1:0] op_a_sel;
  assign op_a_sel = (ctrl.sel_a == A_QA && ctrl.sel_b == B_PER) ?
                    A_W'({1'b0, volt}) : op_a;

  assign lt_a = mag < {{(Q_W-T_W){1'b0}}, t};
  assign lt_b = mag < {1'b0, prod};

  always_comb begin
    priority if (lt_a) begin
      kind_next = KIND_NONE;
    end else if (lt_b) begin
      kind_next = pos ? KIND_HALF_UP : KIND_HALF_DN;
    end else begin
      kind_next = pos ? KIND_FULL_UP : KIND_FULL_DN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= op_a_sel * op_b;
      if (ctrl.t_ld) begin
        t <= prod[T_W-1:0];
      end
      unique case (ctrl.acc_op)
        ACC_LOAD: acc <= Q_W'(prod);
        ACC_ADD:  acc <= acc + Q_W'(prod);
        default:  acc <= acc;
      endcase
      if (ctrl.mag_ld) begin
        mag <= acc[Q_W-1] ? unsigned'(-acc) : unsigned'(acc);
        pos <= !acc[Q_W-1] && (acc != '0);
      end
      if (ctrl.band_ld) begin
        kind <= kind_next;
      end
    end
  end

endmodule

// ----- hdl/mppt_duty_cycle_tracker_top.sv -----
// a result is raised when the program reaches its done step, or its
// first-tick step on the first transaction after reset
// throughput: a new item waits until the last has finished, the pace set by
// the six products that pass in turn through the single shared multiplier
// reset: synchronous rst clears the sequencer, the output valid and the
// started flag, and loads the register defaults
// ----------------------------------------------------------------------------
// mppt_duty_cycle_tracker_top
// Incremental duty cycle MPPT tracker with a microcoded sequencer
// ----------------------------------------------------------------------------
module mppt_duty_cycle_tracker_top #(
  parameter int PWM_PERIOD = mdct_pkg::PWM_PERIOD_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [mdct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mdct_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mdct_pkg::VOLT_W-1:0]        s_tdata,  // pv_voltage
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // applied_duty, next_duty, step_kind, saturated, zero padding
  output logic [mdct_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import mdct_pkg::*;

  logic [QTH_W-1:0]  q_alpha;
  logic [QTH_W-1:0]  q_beta;
  logic [DUTY_W-1:0] duty_min;
  logic [DUTY_W-1:0] duty_max;
  logic [DUTY_W-1:0] start_duty;
  logic [DUTY_W-1:0] first_duty;

  logic              busy;
  logic              started;
  logic [STEP_W-1:0] step;
  ctrl_t             ctrl;

  logic [VOLT_W-1:0] volt;
  logic [VOLT_W-1:0] vprev;
  logic [DUTY_W-1:0] cur;
  logic [DUTY_W-1:0] prv;
  step_kind_t        kind;

  logic [DUTY_W-1:0] out_applied;
  logic [DUTY_W-1:0] out_next;
  logic [KIND_W-1:0] out_kind;
  logic              out_sat;

  logic              out_free;
  logic              fin;
  logic signed [DUTY_W+2:0] inc2;
  logic signed [DUTY_W+2:0] n2;
  logic signed [DUTY_W+2:0] max2;
  logic signed [DUTY_W+2:0] min2;
  logic [DUTY_W-1:0] duty_next;
  logic              sat_next;

  assign ctrl     = mdct_ucode(step);
  assign s_tready = !busy;
  assign out_free = !m_tvalid || m_tready;
  assign fin      = busy && (ctrl.done || ctrl.first) && out_free;
  assign m_tdata  = {(OUT_DATA_W - 2 * DUTY_W - KIND_W - 1)'(0),
                     out_sat, out_kind, out_next, out_applied};

  mdct_datapath #(
    .PWM_PERIOD(PWM_PERIOD)
  ) u_datapath (
    .clk    (clk),
    .en     (busy),
    .ctrl   (ctrl),
    .cur    (cur),
    .prv    (prv),
    .volt   (volt),
    .vprev  (vprev),
    .q_alpha(q_alpha),
    .q_beta (q_beta),
    .kind   (kind)
  );

  // stepping in half counts
  always_comb begin
    unique case (kind)
      KIND_HALF_UP: inc2 = (DUTY_W+3)'(1);
      KIND_HALF_DN: inc2 = -(DUTY_W+3)'(1);
      KIND_FULL_UP: inc2 = (DUTY_W+3)'(2);
      KIND_FULL_DN: inc2 = -(DUTY_W+3)'(2);
      default:      inc2 = '0;
    endcase
    n2   = signed'({2'b00, cur, 1'b0}) + inc2;
    max2 = signed'({2'b00, duty_max, 1'b0});
    min2 = signed'({2'b00, duty_min, 1'b0});
    priority if (n2 >= max2) begin
      duty_next = duty_max;
      sat_next  = 1'b1;
    end else if (n2 <= min2) begin
      duty_next = duty_min;
      sat_next  = 1'b1;
    end else begin
      duty_next = n2[DUTY_W:1];
      sat_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_alpha    <= Q_ALPHA_RST;
      q_beta     <= Q_BETA_RST;
      duty_min   <= DUTY_MIN_RST;
      duty_max   <= DUTY_MAX_RST;
      start_duty <= START_DUTY_RST;
      first_duty <= FIRST_DUTY_RST;
      busy       <= 1'b0;
      started    <= 1'b0;
      step       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_Q_ALPHA:    q_alpha    <= cfg_wdata[QTH_W-1:0];
          REG_Q_BETA:     q_beta     <= cfg_wdata[QTH_W-1:0];
          REG_DUTY_MIN:   duty_min   <= cfg_wdata[DUTY_W-1:0];
          REG_DUTY_MAX:   duty_max   <= cfg_wdata[DUTY_W-1:0];
          REG_START_DUTY: start_duty <= cfg_wdata[DUTY_W-1:0];
          REG_FIRST_DUTY: first_duty <= cfg_wdata[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (m_tready && !fin) begin
        m_tvalid <= 1'b0;
      end
      if (s_tvalid && s_tready) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (ctrl.br_first && !started) begin
          step <= ctrl.target;
        end else if (ctrl.done || ctrl.first) begin
          if (out_free) begin
            busy     <= 1'b0;
            m_tvalid <= 1'b1;
            if (ctrl.first) begin
              started <= 1'b1;
            end
          end
        end else begin
          step <= step + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      volt <= s_tdata;
    end
    if (fin) begin
      vprev <= volt;
      if (ctrl.first) begin
        cur         <= first_duty;
        prv         <= start_duty;
        out_applied <= start_duty;
        out_next    <= first_duty;
        out_kind    <= KIND_NONE;
        out_sat     <= 1'b0;
      end else begin
        cur         <= duty_next;
        prv         <= cur;
        out_applied <= cur;
        out_next    <= duty_next;
        out_kind    <= kind;
        out_sat     <= sat_next;
      end
    end
  end

`ifndef SYNTH
  a_first_once : assert property (@(posedge clk) disable iff (rst)
    (busy && step == STEP_FIRST) |-> !started)
    else $error("first-tick step reached after start");

  a_step_range : assert property (@(posedge clk) disable iff (rst)
    busy |-> (step <= STEP_FIRST))
    else $error("step counter outside program");

  a_out_source : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(busy))
    else $error("result raised without work in flight");

  a_no_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (busy && !fin) |=> !(s_tvalid && s_tready) || !$past(busy)
      || $past(fin))
    else $error("transaction taken during work");
`endif

endmodule
